// ----- hw/rtl/vfm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_pkg: shared definitions for the voxel face mesher
// Field widths, item and register codes, controller state, command/status
// bundles, the colour table and the corner offset table.
// ----------------------------------------------------------------------------
package vfm_pkg;

   // field widths
   localparam int CoordW    = 5;
   localparam int KindW     = 4;
   localparam int ModeW     = 2;
   localparam int VertexW   = 18;
   localparam int ColorW    = 24;
   localparam int SlotW     = 20;
   localparam int SideW     = 3;
   localparam int SideCount = 6;
   localparam int CornerW   = 2;
   localparam int CsrIndexW = 2;
   localparam int AddrW     = 3 * CoordW;
   localparam int VolDepth  = 1 << AddrW;
   localparam int ProbeW    = 3;

   // largest usable extent per axis and the bound below which a block type has a colour
   localparam logic [CoordW-1:0] MaxDim     = CoordW'(31);
   localparam int                ColorCount = 9;
   localparam logic [CoordW-1:0] SizeReset  = CoordW'(16);

   // item modes
   localparam logic [ModeW-1:0] MODE_WRITE   = 2'd0;
   localparam logic [ModeW-1:0] MODE_EMIT    = 2'd1;
   localparam logic [ModeW-1:0] MODE_RESTART = 2'd2;

   // register indexes
   localparam logic [CsrIndexW-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_SIZE_Z = 2'd2;

   // faces, in emission order
   localparam logic [SideW-1:0] SIDE_BOTTOM = 3'd0;
   localparam logic [SideW-1:0] SIDE_TOP    = 3'd1;
   localparam logic [SideW-1:0] SIDE_WEST   = 3'd2;
   localparam logic [SideW-1:0] SIDE_EAST   = 3'd3;
   localparam logic [SideW-1:0] SIDE_FRONT  = 3'd4;
   localparam logic [SideW-1:0] SIDE_BACK   = 3'd5;

   // probe step at which the last neighbour has been captured
   localparam logic [ProbeW-1:0] PROBE_LAST = ProbeW'(SideCount);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_PROBE,
      ST_EMIT
   } vfm_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic clear_step;
      logic check;
      logic probe;
      logic load;
   } vfm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic start_emit;
      logic type_zero;
      logic boundary;
      logic probe_done;
      logic mask_empty;
      logic out_free;
      logic last_vertex;
   } vfm_stat_type;

   // clamp a size register to the usable extent
   function automatic logic [CoordW-1:0] eff_size(input logic [CoordW-1:0] size);
      eff_size = (size > MaxDim) ? MaxDim : size;
   endfunction

   // packed colour r | g<<8 | b<<16; types without a colour give zero
   function automatic logic [ColorW-1:0] kind_color(input logic [KindW-1:0] kind);
      logic [ColorW-1:0] rgb;
      case (kind)
         4'd1:    rgb = 24'h008200;
         4'd2:    rgb = 24'h820000;
         4'd3:    rgb = 24'h000082;
         4'd4:    rgb = 24'h0085FF;
         4'd5:    rgb = 24'h00B4B4;
         4'd6:    rgb = 24'hC8C800;
         4'd7:    rgb = 24'h336699;
         4'd8:    rgb = 24'hFFFFFF;
         default: rgb = '0;
      endcase
      if (32'(kind) >= ColorCount) begin
         rgb = '0;
      end
      kind_color = rgb;
   endfunction

   // corner offset {dx, dy, dz} for one face and corner
   function automatic logic [2:0] corner_offset(input logic [SideW-1:0] side,
                                                input logic [CornerW-1:0] corner);
      logic [11:0] row;
      case (side)
         SIDE_BOTTOM: row = {3'b001, 3'b101, 3'b100, 3'b000};
         SIDE_TOP:    row = {3'b110, 3'b111, 3'b011, 3'b010};
         SIDE_WEST:   row = {3'b101, 3'b111, 3'b110, 3'b100};
         SIDE_EAST:   row = {3'b010, 3'b011, 3'b001, 3'b000};
         SIDE_FRONT:  row = {3'b100, 3'b110, 3'b010, 3'b000};
         SIDE_BACK:   row = {3'b011, 3'b111, 3'b101, 3'b001};
         default:     row = '0;
      endcase
      corner_offset = row[corner*3 +: 3];
   endfunction

endpackage

// ----- hw/rtl/vfm_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_channels: request and response channels of the voxel face mesher
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface vfm_req_if import vfm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ModeW-1:0]  mode;
   logic [CoordW-1:0] pos_x;
   logic [CoordW-1:0] pos_y;
   logic [CoordW-1:0] pos_z;
   logic [KindW-1:0]  block_kind;

   modport source (output valid, mode, pos_x, pos_y, pos_z, block_kind, input ready);
   modport sink   (input valid, mode, pos_x, pos_y, pos_z, block_kind, output ready);
endinterface

interface vfm_rsp_if import vfm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VertexW-1:0] vertex_word;
   logic [ColorW-1:0]  color_word;
   logic [SlotW-1:0]   vertex_slot;
   logic               last;

   modport source (output valid, vertex_word, color_word, vertex_slot, last, input ready);
   modport sink   (input valid, vertex_word, color_word, vertex_slot, last, output ready);
endinterface

// ----- hw/rtl/voxel_face_mesher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_mesher: voxel volume with face-culling quad emission
// Usage:
//   req_ch carries one item per beat: mode 0 writes block_kind at pos_x/y/z,
//   mode 2 zeroes the running vertex counter, mode 1 emits the visible faces
//   of one voxel. Writes and emits outside the configured size are dropped.
//   rsp_ch carries one vertex per beat with its colour, running slot and a
//   last flag on the final vertex of the voxel.
//   csr_* sets size_x, size_y, size_z (index 0, 1, 2); write only when idle.
// Sequence:
//   write, restart and out-of-range items are done in the intake state; an
//   empty voxel returns to intake after the check. An emit reads the voxel,
//   checks it, and for an interior voxel reads its six neighbours; vertices
//   then follow one per cycle while the response side is not stalled, up to
//   24 per voxel, none for a hidden voxel.
// Reset: size registers, clear pointer, vertex counter and output valid flag
//   return to defaults, then a clearing pass writes zero to all 32768 volume
//   entries, one per cycle, with req_ch.ready low; size writes are still taken.
// Stall: a held response beat stops emission; the next item is taken while
//   the final vertex still waits in the output register.
// ----------------------------------------------------------------------------
module voxel_face_mesher import vfm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   vfm_req_if.sink              req_ch,
   vfm_rsp_if.source            rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CoordW-1:0]    csr_write_data
);

   vfm_cmd_type  cmd;
   vfm_stat_type stat;
   logic         req_ready;

   vfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vfm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_ch.mode),
      .req_pos_x        (req_ch.pos_x),
      .req_pos_y        (req_ch.pos_y),
      .req_pos_z        (req_ch.pos_z),
      .req_block_kind   (req_ch.block_kind),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_vertex_word  (rsp_ch.vertex_word),
      .rsp_color_word   (rsp_ch.color_word),
      .rsp_vertex_slot  (rsp_ch.vertex_slot),
      .rsp_last         (rsp_ch.last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   assign req_ch.ready = req_ready;

endmodule

// ----- hw/rtl/vfm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_ctrl: sequencer of the voxel face mesher
// Steps through the clearing pass, item intake, voxel check, neighbour
// probes and vertex emission, driving the datapath by command bundle.
// ----------------------------------------------------------------------------
module vfm_ctrl import vfm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  vfm_stat_type stat,
   output vfm_cmd_type  cmd
);

   vfm_state_type state_ff;
   vfm_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && stat.start_emit) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.type_zero)     state_in = ST_IDLE;
            else if (stat.boundary) state_in = ST_EMIT;
            else                    state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (stat.probe_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.mask_empty)                            state_in = ST_IDLE;
            else if (stat.out_free && stat.last_vertex)     state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_CHECK: cmd.check = 1'b1;
         ST_PROBE: cmd.probe = 1'b1;
         ST_EMIT:  cmd.load  = !stat.mask_empty && stat.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // reset always restarts the clearing pass
   assert property (@(posedge clock) reset |=> state_ff == ST_CLEAR)
      else $error("vfm_ctrl: reset did not enter the clearing pass");

   // a vertex is loaded only with a face pending and the output slot free
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!stat.mask_empty && stat.out_free))
      else $error("vfm_ctrl: vertex load without pending face or free slot");
`endif

endmodule

// ----- hw/rtl/vfm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_datapath: volume store, face mask and vertex generation
// Holds the size registers, the 32768-entry volume memory, the item
// registers, the visible-face mask, the vertex counter and the output stage.
// ----------------------------------------------------------------------------
module vfm_datapath import vfm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  vfm_cmd_type          cmd,
   output vfm_stat_type         stat,
   input  logic [ModeW-1:0]     req_mode,
   input  logic [CoordW-1:0]    req_pos_x,
   input  logic [CoordW-1:0]    req_pos_y,
   input  logic [CoordW-1:0]    req_pos_z,
   input  logic [KindW-1:0]     req_block_kind,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VertexW-1:0]   rsp_vertex_word,
   output logic [ColorW-1:0]    rsp_color_word,
   output logic [SlotW-1:0]     rsp_vertex_slot,
   output logic                 rsp_last,
   input  logic                 csr_write_enable,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CoordW-1:0]    csr_write_data
);

   logic [CoordW-1:0]    size_x_ff, size_y_ff, size_z_ff;
   logic [CoordW-1:0]    size_x_in, size_y_in, size_z_in;
   logic [CoordW-1:0]    sx, sy, sz;
   logic [AddrW-1:0]     clear_ff, clear_in;
   logic [CoordW-1:0]    pos_x_ff, pos_y_ff, pos_z_ff;
   logic [CoordW-1:0]    pos_x_in, pos_y_in, pos_z_in;
   logic [KindW-1:0]     type_ff, type_in;
   logic [SideCount-1:0] mask_ff, mask_in;
   logic [ProbeW-1:0]    probe_ff, probe_in;
   logic [CornerW-1:0]   corner_ff, corner_in;
   logic [SlotW-1:0]     count_ff, count_in;
   logic                 out_valid_ff, out_valid_in;
   logic [VertexW-1:0]   out_vertex_ff, out_vertex_in;
   logic [ColorW-1:0]    out_color_ff, out_color_in;
   logic [SlotW-1:0]     out_slot_ff, out_slot_in;
   logic                 out_last_ff, out_last_in;

   logic [KindW-1:0]     mem [VolDepth];
   logic [KindW-1:0]     rd_data_ff;
   logic [AddrW-1:0]     mem_addr;
   logic                 mem_we;
   logic [KindW-1:0]     mem_wdata;
   logic [AddrW-1:0]     probe_addr;

   logic                 req_inside;
   logic                 boundary;
   logic [SideCount-1:0] side_onehot;
   logic [SideW-1:0]     side_idx;
   logic                 last_vertex;
   logic [2:0]           offset;
   logic [CoordW-1:0]    vx, vy, vz;

   // size registers
   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_in = csr_write_data;
            CSR_SIZE_Y: size_y_in = csr_write_data;
            CSR_SIZE_Z: size_z_in = csr_write_data;
            default:    size_x_in = size_x_ff;
         endcase
      end
   end

   assign sx = eff_size(size_x_ff);
   assign sy = eff_size(size_y_ff);
   assign sz = eff_size(size_z_ff);

   // position checks
   assign req_inside = (req_pos_x < sx) && (req_pos_y < sy) && (req_pos_z < sz);
   assign boundary   = (pos_x_ff == '0) || (pos_x_ff == sx - CoordW'(1)) ||
                       (pos_y_ff == '0) || (pos_y_ff == sy - CoordW'(1)) ||
                       (pos_z_ff == '0) || (pos_z_ff == sz - CoordW'(1));

   // neighbour address per probe step, faces in emission order
   always_comb begin
      case (probe_ff)
         3'd0:    probe_addr = {pos_x_ff, pos_y_ff - CoordW'(1), pos_z_ff};
         3'd1:    probe_addr = {pos_x_ff, pos_y_ff + CoordW'(1), pos_z_ff};
         3'd2:    probe_addr = {pos_x_ff + CoordW'(1), pos_y_ff, pos_z_ff};
         3'd3:    probe_addr = {pos_x_ff - CoordW'(1), pos_y_ff, pos_z_ff};
         3'd4:    probe_addr = {pos_x_ff, pos_y_ff, pos_z_ff - CoordW'(1)};
         3'd5:    probe_addr = {pos_x_ff, pos_y_ff, pos_z_ff + CoordW'(1)};
         default: probe_addr = {pos_x_ff, pos_y_ff, pos_z_ff};
      endcase
   end

   // memory port: clearing pass, item write or self read, neighbour read
   always_comb begin
      if (cmd.clear_step) begin
         mem_addr = clear_ff;
      end else if (cmd.accept) begin
         mem_addr = {req_pos_x, req_pos_y, req_pos_z};
      end else begin
         mem_addr = probe_addr;
      end
      mem_we    = cmd.clear_step ||
                  (cmd.accept && req_mode == MODE_WRITE && req_inside);
      mem_wdata = cmd.clear_step ? '0 : req_block_kind;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   // current face: lowest pending bit of the mask
   assign side_onehot = mask_ff & (~mask_ff + SideCount'(1));
   always_comb begin
      side_idx = '0;
      for (int i = SideCount - 1; i >= 0; i--) begin
         if (mask_ff[i]) side_idx = SideW'(i);
      end
   end
   assign last_vertex = (corner_ff == '1) && ((mask_ff & ~side_onehot) == '0);

   // corner coordinates
   assign offset = corner_offset(side_idx, corner_ff);
   assign vx     = pos_x_ff + CoordW'(offset[2]);
   assign vy     = pos_y_ff + CoordW'(offset[1]);
   assign vz     = pos_z_ff + CoordW'(offset[0]);

   // item registers, face mask, probe and corner counters
   always_comb begin
      clear_in  = cmd.clear_step ? clear_ff + AddrW'(1) : clear_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      pos_z_in  = pos_z_ff;
      type_in   = type_ff;
      mask_in   = mask_ff;
      probe_in  = probe_ff;
      corner_in = corner_ff;
      count_in  = count_ff;
      if (cmd.accept) begin
         pos_x_in = req_pos_x;
         pos_y_in = req_pos_y;
         pos_z_in = req_pos_z;
         if (req_mode == MODE_RESTART) count_in = '0;
      end
      if (cmd.check) begin
         type_in   = rd_data_ff;
         mask_in   = boundary ? '1 : '0;
         probe_in  = '0;
         corner_in = '0;
      end
      if (cmd.probe) begin
         probe_in = probe_ff + ProbeW'(1);
         for (int i = 0; i < SideCount; i++) begin
            if (probe_ff == ProbeW'(i + 1)) mask_in[i] = (rd_data_ff == '0);
         end
      end
      if (cmd.load) begin
         corner_in = corner_ff + CornerW'(1);
         count_in  = count_ff + SlotW'(1);
         if (corner_ff == '1) mask_in = mask_ff & ~side_onehot;
      end
   end

   // output stage
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_vertex_in = out_vertex_ff;
      out_color_in  = out_color_ff;
      out_slot_in   = out_slot_ff;
      out_last_in   = out_last_ff;
      if (cmd.load) begin
         out_valid_in  = 1'b1;
         out_vertex_in = {side_idx, vx, vy, vz};
         out_color_in  = kind_color(type_ff);
         out_slot_in   = count_ff;
         out_last_in   = last_vertex;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff    <= SizeReset;
         size_y_ff    <= SizeReset;
         size_z_ff    <= SizeReset;
         clear_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         size_x_ff    <= size_x_in;
         size_y_ff    <= size_y_in;
         size_z_ff    <= size_z_in;
         clear_ff     <= clear_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      pos_z_ff      <= pos_z_in;
      type_ff       <= type_in;
      mask_ff       <= mask_in;
      probe_ff      <= probe_in;
      corner_ff     <= corner_in;
      out_vertex_ff <= out_vertex_in;
      out_color_ff  <= out_color_in;
      out_slot_ff   <= out_slot_in;
      out_last_ff   <= out_last_in;
   end

   // status to the controller
   always_comb begin
      stat.clear_done  = (clear_ff == '1);
      stat.start_emit  = (req_mode == MODE_EMIT) && req_inside;
      stat.type_zero   = (rd_data_ff == '0);
      stat.boundary    = boundary;
      stat.probe_done  = (probe_ff == PROBE_LAST);
      stat.mask_empty  = (mask_ff == '0);
      stat.out_free    = !out_valid_ff || rsp_ready;
      stat.last_vertex = last_vertex;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_vertex_word = out_vertex_ff;
   assign rsp_color_word  = out_color_ff;
   assign rsp_vertex_slot = out_slot_ff;
   assign rsp_last        = out_last_ff;

`ifndef SYNTH
   // a waiting beat is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!out_valid_ff || rsp_ready))
      else $error("vfm_datapath: output beat overwritten while stalled");

   // the final vertex of a voxel leaves no face pending
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load && last_vertex) |=> (mask_ff == '0))
      else $error("vfm_datapath: faces left after final vertex");

   // a restart item zeroes the vertex counter
   assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_mode == MODE_RESTART) |=> (count_ff == '0))
      else $error("vfm_datapath: vertex counter not restarted");
`endif

endmodule

// ----- sim/vfm_vertex_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfm_vertex_checker: vertex stream scoreboard for the voxel face mesher
// Watches the request, response and size-register ports. Keeps its own copy
// of the voxel volume, sizes and running slot counter. Queues the vertices
// each accepted request should produce, then compares every response beat
// field by field against the oldest queued vertex.
// ----------------------------------------------------------------------------
module vfm_vertex_checker import vfm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   vfm_req_if                   req_ch,
   vfm_rsp_if                   rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CoordW-1:0]    csr_write_data,
   output int                   fail_count,
   output int                   vertices_due
);

   typedef struct packed {
      logic [VertexW-1:0] vertex_word;
      logic [ColorW-1:0]  color_word;
      logic [SlotW-1:0]   vertex_slot;
      logic               last;
   } vertex_type;

   // corner offsets {dx, dy, dz}, four per face, faces in emission order
   localparam logic [2:0] FaceCorners [SideCount][4] = '{
      '{3'b000, 3'b100, 3'b101, 3'b001},
      '{3'b010, 3'b011, 3'b111, 3'b110},
      '{3'b100, 3'b110, 3'b111, 3'b101},
      '{3'b000, 3'b001, 3'b011, 3'b010},
      '{3'b000, 3'b010, 3'b110, 3'b100},
      '{3'b001, 3'b101, 3'b111, 3'b011}
   };

   // packed r | g<<8 | b<<16 per block type below ColorCount; type 0 gives zero
   localparam logic [ColorW-1:0] KindRgb [ColorCount] = '{
      24'h000000, 24'h008200, 24'h820000, 24'h000082, 24'h0085FF,
      24'h00B4B4, 24'hC8C800, 24'h336699, 24'hFFFFFF
   };

   logic [KindW-1:0]  voxels [VolDepth];
   logic [SlotW-1:0]  slot_counter;
   logic [CoordW-1:0] extent_x, extent_y, extent_z;
   vertex_type        vertices_expected [$];
   int                reported;

   function automatic logic [AddrW-1:0] voxel_addr(input logic [CoordW-1:0] x,
                                                   input logic [CoordW-1:0] y,
                                                   input logic [CoordW-1:0] z);
      return {x, y, z};
   endfunction

   // apply one request beat to the volume and queue the vertices it yields
   task automatic mesh_voxel(input logic [ModeW-1:0]  mode,
                             input logic [CoordW-1:0] x,
                             input logic [CoordW-1:0] y,
                             input logic [CoordW-1:0] z,
                             input logic [KindW-1:0]  kind);
      logic [CoordW-1:0]    sx, sy, sz;
      logic [CoordW-1:0]    vx, vy, vz;
      logic [KindW-1:0]     stored;
      logic [SideCount-1:0] faces;
      logic [2:0]           offs;
      logic                 in_range;
      int                   total;
      int                   n;
      vertex_type           v;
      sx = (extent_x > MaxDim) ? MaxDim : extent_x;
      sy = (extent_y > MaxDim) ? MaxDim : extent_y;
      sz = (extent_z > MaxDim) ? MaxDim : extent_z;
      in_range = (x < sx) && (y < sy) && (z < sz);
      if (mode == MODE_RESTART) begin
         slot_counter = '0;
         return;
      end
      if (mode == MODE_WRITE) begin
         if (in_range) voxels[voxel_addr(x, y, z)] = kind;
         return;
      end
      if (mode != MODE_EMIT || !in_range) return;
      stored = voxels[voxel_addr(x, y, z)];
      if (stored == '0) return;

      // boundary voxels show every face, interior ones only those facing air
      if (x == 0 || x == sx - 1 || y == 0 || y == sy - 1 || z == 0 || z == sz - 1) begin
         faces = '1;
      end else begin
         faces[SIDE_BOTTOM] = voxels[voxel_addr(x, y - 1'b1, z)] == '0;
         faces[SIDE_TOP]    = voxels[voxel_addr(x, y + 1'b1, z)] == '0;
         faces[SIDE_WEST]   = voxels[voxel_addr(x + 1'b1, y, z)] == '0;
         faces[SIDE_EAST]   = voxels[voxel_addr(x - 1'b1, y, z)] == '0;
         faces[SIDE_FRONT]  = voxels[voxel_addr(x, y, z - 1'b1)] == '0;
         faces[SIDE_BACK]   = voxels[voxel_addr(x, y, z + 1'b1)] == '0;
      end
      total = 4 * $countones(faces);
      n = 0;
      for (int s = 0; s < SideCount; s++) begin
         if (!faces[s]) continue;
         for (int c = 0; c < 4; c++) begin
            offs = FaceCorners[s][c];
            vx = x + offs[2];
            vy = y + offs[1];
            vz = z + offs[0];
            v.vertex_word = {SideW'(s), vx, vy, vz};
            v.color_word  = (int'(stored) < ColorCount) ? KindRgb[stored] : '0;
            v.vertex_slot = slot_counter;
            v.last        = (n + 1 == total);
            vertices_expected.push_back(v);
            slot_counter++;
            n++;
         end
      end
   endtask

   // match one response beat against the oldest queued vertex
   task automatic check_vertex(input vertex_type got);
      vertex_type want;
      if (vertices_expected.size() == 0) begin
         fail_count++;
         if (reported < 10) begin
            $display("unexpected vertex: word %h colour %h slot %0d last %b",
                     got.vertex_word, got.color_word, got.vertex_slot, got.last);
         end
         reported++;
         return;
      end
      want = vertices_expected.pop_front();
      if (got.vertex_word !== want.vertex_word || got.color_word !== want.color_word ||
          got.vertex_slot !== want.vertex_slot || got.last !== want.last) begin
         fail_count++;
         if (reported < 10) begin
            $display("vertex mismatch: expected word %h colour %h slot %0d last %b",
                     want.vertex_word, want.color_word, want.vertex_slot, want.last);
            $display("                 got      word %h colour %h slot %0d last %b",
                     got.vertex_word, got.color_word, got.vertex_slot, got.last);
         end
         reported++;
      end
   endtask

   // sample all ports on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (voxels[i]) voxels[i] = '0;
         slot_counter = '0;
         extent_x     = SizeReset;
         extent_y     = SizeReset;
         extent_z     = SizeReset;
         fail_count   = 0;
         reported     = 0;
         vertices_expected.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_vertex({rsp_ch.vertex_word, rsp_ch.color_word, rsp_ch.vertex_slot,
                          rsp_ch.last});
         end
         if (req_ch.valid && req_ch.ready) begin
            mesh_voxel(req_ch.mode, req_ch.pos_x, req_ch.pos_y, req_ch.pos_z,
                       req_ch.block_kind);
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SIZE_X: extent_x = csr_write_data;
               CSR_SIZE_Y: extent_y = csr_write_data;
               CSR_SIZE_Z: extent_z = csr_write_data;
               default: ;
            endcase
         end
      end
      vertices_due = vertices_expected.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the voxel face mesher
// Drives write, emit and restart requests and the size registers, toggles
// backpressure on both channels and leaves checking to the vertex checker.
// Directed cases and random traffic alternate over several volume sizes.
// ----------------------------------------------------------------------------
module testbench;
   import vfm_pkg::*;

   localparam int HalfPeriod   = 10;
   localparam int ResetCycles  = 10;
   localparam int LongHold     = 400;
   localparam int SettleCycles = 40;
   localparam int CycleLimit   = 250000;

   // mode code the block must ignore
   localparam logic [ModeW-1:0] ModeUnused = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CsrIndexW-1:0] csr_index = CSR_SIZE_X;
   logic [CoordW-1:0]    csr_write_data = '0;

   int          send_idle_pct = 14;
   int          recv_idle_pct = 46;
   bit          hold_off_pending = 1'b0;
   int          cycle_count = 0;
   int          fail_count;
   int          vertices_due;
   logic [CoordW-1:0] span_x = SizeReset;
   logic [CoordW-1:0] span_y = SizeReset;
   logic [CoordW-1:0] span_z = SizeReset;

   vfm_req_if req_ch ();
   vfm_rsp_if rsp_ch ();

   voxel_face_mesher uut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   vfm_vertex_checker mesh_check (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .vertices_due     (vertices_due)
   );

   always #(HalfPeriod) clock = ~clock;

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response backpressure, with one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LongHold) @(negedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // offer one request beat; entered and left on a falling edge
   task automatic offer(input logic [ModeW-1:0]  mode,
                        input logic [CoordW-1:0] x,
                        input logic [CoordW-1:0] y,
                        input logic [CoordW-1:0] z,
                        input logic [KindW-1:0]  kind);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= mode;
      req_ch.pos_x      <= x;
      req_ch.pos_y      <= y;
      req_ch.pos_z      <= z;
      req_ch.block_kind <= kind;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // drop valid and wait for every queued vertex plus in-flight work
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (vertices_due != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic set_sizes(input logic [CoordW-1:0] sx,
                            input logic [CoordW-1:0] sy,
                            input logic [CoordW-1:0] sz);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SIZE_X;
      csr_write_data   <= sx;
      @(negedge clock);
      csr_index      <= CSR_SIZE_Y;
      csr_write_data <= sy;
      @(negedge clock);
      csr_index      <= CSR_SIZE_Z;
      csr_write_data <= sz;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      span_x = sx;
      span_y = sy;
      span_z = sz;
   endtask

   // mostly a small corner cluster so neighbours meet, sometimes anywhere
   function automatic logic [CoordW-1:0] pick_coord(input logic [CoordW-1:0] extent);
      int lim;
      lim = (extent > 6) ? 6 : int'(extent);
      if (lim == 0 || $urandom_range(99) < 12) return CoordW'($urandom_range(30, 0));
      return CoordW'($urandom_range(lim - 1, 0));
   endfunction

   task automatic random_items(input int count);
      int roll;
      logic [KindW-1:0] kind;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         kind = ($urandom_range(99) < 15) ? '0 : KindW'($urandom_range(8, 1));
         if (roll < 46) begin
            offer(MODE_WRITE, pick_coord(span_x), pick_coord(span_y), pick_coord(span_z),
                  kind);
         end else if (roll < 94) begin
            offer(MODE_EMIT, pick_coord(span_x), pick_coord(span_y), pick_coord(span_z),
                  KindW'($urandom_range(15, 0)));
         end else begin
            offer(MODE_RESTART, pick_coord(span_x), pick_coord(span_y),
                  pick_coord(span_z), kind);
         end
      end
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.mode       = MODE_WRITE;
      req_ch.pos_x      = '0;
      req_ch.pos_y      = '0;
      req_ch.pos_z      = '0;
      req_ch.block_kind = '0;
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty, boundary, culled interior, out of range, odd modes
      offer(MODE_EMIT,    5'd5,  5'd5,  5'd5,  4'd0);
      offer(MODE_WRITE,   5'd0,  5'd0,  5'd0,  4'd1);
      offer(MODE_EMIT,    5'd0,  5'd0,  5'd0,  4'd0);
      offer(MODE_WRITE,   5'd5,  5'd5,  5'd5,  4'd8);
      offer(MODE_WRITE,   5'd5,  5'd4,  5'd5,  4'd3);
      offer(MODE_WRITE,   5'd6,  5'd5,  5'd5,  4'd2);
      offer(MODE_WRITE,   5'd5,  5'd5,  5'd6,  4'd7);
      offer(MODE_EMIT,    5'd5,  5'd5,  5'd5,  4'd0);
      offer(MODE_WRITE,   5'd15, 5'd15, 5'd15, 4'd5);
      offer(MODE_EMIT,    5'd15, 5'd15, 5'd15, 4'd0);
      offer(MODE_WRITE,   5'd16, 5'd3,  5'd3,  4'd4);
      offer(MODE_EMIT,    5'd16, 5'd3,  5'd3,  4'd0);
      offer(MODE_EMIT,    5'd3,  5'd3,  5'd3,  4'd0);
      offer(ModeUnused,   5'd5,  5'd5,  5'd5,  4'd0);
      offer(MODE_EMIT,    5'd5,  5'd5,  5'd5,  4'd0);
      offer(MODE_RESTART, 5'd0,  5'd0,  5'd0,  4'd0);
      offer(MODE_EMIT,    5'd0,  5'd0,  5'd0,  4'd0);
      // types without a colour
      offer(MODE_WRITE,   5'd7,  5'd7,  5'd7,  4'd9);
      offer(MODE_WRITE,   5'd8,  5'd7,  5'd7,  4'd15);
      offer(MODE_EMIT,    5'd7,  5'd7,  5'd7,  4'd0);
      offer(MODE_EMIT,    5'd8,  5'd7,  5'd7,  4'd0);
      offer(MODE_WRITE,   5'd5,  5'd5,  5'd5,  4'd0);
      offer(MODE_EMIT,    5'd5,  5'd5,  5'd5,  4'd0);

      // hold the response side so the block backs up into the request side
      hold_off_pending = 1'b1;
      repeat (6) offer(MODE_EMIT, 5'd0, 5'd0, 5'd0, 4'd0);
      settle();

      set_sizes(5'd5, 5'd5, 5'd5);
      random_items(20);
      settle();

      // swap idling between the sides
      send_idle_pct = 46;
      recv_idle_pct = 14;

      // zero size: everything falls outside
      set_sizes(5'd0, 5'd31, 5'd31);
      offer(MODE_WRITE, 5'd0, 5'd0, 5'd0, 4'd2);
      offer(MODE_EMIT,  5'd0, 5'd0, 5'd0, 4'd0);
      settle();

      set_sizes(5'd31, 5'd31, 5'd31);
      offer(MODE_EMIT,  5'd0,  5'd0,  5'd0,  4'd0);
      offer(MODE_WRITE, 5'd30, 5'd30, 5'd30, 4'd6);
      offer(MODE_EMIT,  5'd30, 5'd30, 5'd30, 4'd0);
      offer(MODE_WRITE, 5'd30, 5'd1,  5'd17, 4'd4);
      offer(MODE_EMIT,  5'd30, 5'd1,  5'd17, 4'd0);
      random_items(25);
      settle();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;

      set_sizes(5'd1, 5'd1, 5'd1);
      offer(MODE_WRITE, 5'd0, 5'd0, 5'd0, 4'd3);
      offer(MODE_EMIT,  5'd0, 5'd0, 5'd0, 4'd0);
      offer(MODE_EMIT,  5'd1, 5'd0, 5'd0, 4'd0);
      settle();

      set_sizes(5'd7, 5'd3, 5'd31);
      random_items(25);
      settle();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
